// ===== hdl/gfr_pkg.sv =====
// Shared types, widths and tables for the gimbal frame rotation block.
// Used by every module under hdl; depends on nothing.
package gfr_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int ANGLE_WIDTH  = 16;
  localparam int TRIG_STAGES  = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int TRIG_W       = 34;
  localparam int COEF_W       = 34;
  localparam int PROD_W       = COORD_WIDTH + COEF_W;
  localparam int SUM_W        = PROD_W + 2;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);

  typedef struct packed {
    logic                          command;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic signed [ANGLE_WIDTH-1:0] pitch_angle;
    logic signed [ANGLE_WIDTH-1:0] yaw_angle;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] rotated_x;
    logic signed [COORD_WIDTH-1:0] rotated_y;
    logic signed [COORD_WIDTH-1:0] rotated_z;
    logic                          saturated;
  } out_word_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [TRIG_W-1:0] z;
    logic                     flip;
  } trig_t;

  typedef struct packed {
    logic                          command;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    trig_t                         pitch;
    trig_t                         yaw;
  } cell_t;

  // arctangent of 2^-i, full turn = 2^32
  function automatic logic signed [TRIG_W-1:0] atan_entry(input int i);
    logic signed [TRIG_W-1:0] r;
    case (i)
      0:  r = TRIG_W'(536870912);
      1:  r = TRIG_W'(316933406);
      2:  r = TRIG_W'(167458907);
      3:  r = TRIG_W'(85004756);
      4:  r = TRIG_W'(42667331);
      5:  r = TRIG_W'(21354465);
      6:  r = TRIG_W'(10680862);
      7:  r = TRIG_W'(5340245);
      8:  r = TRIG_W'(2670163);
      9:  r = TRIG_W'(1335087);
      10: r = TRIG_W'(667544);
      11: r = TRIG_W'(333772);
      12: r = TRIG_W'(166886);
      13: r = TRIG_W'(83443);
      14: r = TRIG_W'(41722);
      15: r = TRIG_W'(20861);
      16: r = TRIG_W'(10430);
      17: r = TRIG_W'(5215);
      18: r = TRIG_W'(2608);
      19: r = TRIG_W'(1304);
      20: r = TRIG_W'(652);
      21: r = TRIG_W'(326);
      22: r = TRIG_W'(163);
      23: r = TRIG_W'(81);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/gimbal_frame_rotation.sv =====
// Top level of the gimbal frame rotation block: angle folding, the CORDIC
// chain and the matrix stages. Depends on gfr_pkg, gfr_cordic_cell, gfr_matrix.
//
// Rotates one point per clock while not stalled, between camera and world
// frames of a pitch/yaw gimbal. Sine and cosine of both angles come from a
// chain of TRIG_STAGES CORDIC cells; four matrix stages follow, and a new
// word is taken every cycle unless stalled. The pipeline advances as a
// whole: it stalls only when the output register holds a word not yet taken.
module gimbal_frame_rotation
  import gfr_pkg::*;
#(
  parameter int TRIG_STAGES_P = TRIG_STAGES
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic  en;
  logic  cv [TRIG_STAGES_P+1];
  cell_t cd [TRIG_STAGES_P+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  function automatic trig_t fold(input logic [ANGLE_WIDTH-1:0] ang);
    trig_t       t;
    logic [31:0] a;
    logic [31:0] q;
    a = {ang, {(32-ANGLE_WIDTH){1'b0}}};
    q = a + 32'h4000_0000;
    t.flip = q[31];
    if (q[31]) begin
      a = a + 32'h8000_0000;
    end
    t.x = CORDIC_GAIN;
    t.y = '0;
    t.z = {{(TRIG_W-32){a[31]}}, a};
    return t;
  endfunction

  always_comb begin
    cv[0]            = in_valid;
    cd[0].command    = in_data.command;
    cd[0].point_x    = in_data.point_x;
    cd[0].point_y    = in_data.point_y;
    cd[0].point_z    = in_data.point_z;
    cd[0].pitch      = fold(in_data.pitch_angle);
    cd[0].yaw        = fold(in_data.yaw_angle);
  end

  for (genvar i = 0; i < TRIG_STAGES_P; i++) begin : g_cell
    gfr_cordic_cell #(.STAGE(i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .prev_valid (cv[i]),
      .prev       (cd[i]),
      .valid      (cv[i+1]),
      .data       (cd[i+1])
    );
  end

  gfr_matrix u_matrix (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .prev_valid (cv[TRIG_STAGES_P]),
    .prev       (cd[TRIG_STAGES_P]),
    .valid      (out_valid),
    .data       (out_data)
  );

endmodule

// ===== hdl/gfr_cordic_cell.sv =====
// One CORDIC rotation step for both angles, with the point carried along.
// Depends on gfr_pkg.
module gfr_cordic_cell
  import gfr_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  prev_valid,
  input  cell_t prev,
  output logic  valid,
  output cell_t data
);

  localparam logic signed [TRIG_W-1:0] ATAN = atan_entry(STAGE);

  function automatic trig_t step(input trig_t t);
    trig_t r;
    logic signed [TRIG_W-1:0] xs;
    logic signed [TRIG_W-1:0] ys;
    xs = t.x >>> STAGE;
    ys = t.y >>> STAGE;
    r.flip = t.flip;
    if (!t.z[TRIG_W-1]) begin
      r.x = t.x - ys;
      r.y = t.y + xs;
      r.z = t.z - ATAN;
    end else begin
      r.x = t.x + ys;
      r.y = t.y - xs;
      r.z = t.z + ATAN;
    end
    return r;
  endfunction

  cell_t data_next;

  always_comb begin
    data_next       = prev;
    data_next.pitch = step(prev.pitch);
    data_next.yaw   = step(prev.yaw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

// ===== hdl/gfr_matrix.sv =====
// Rotation matrix build, coordinate products, rounding and saturation.
// Four pipeline stages after the CORDIC chain; depends on gfr_pkg.
module gfr_matrix
  import gfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      prev_valid,
  input  cell_t     prev,
  output logic      valid,
  output out_word_t data
);

  localparam logic signed [2*TRIG_W-1:0] HALF_T = (2*TRIG_W)'(1) <<< 29;
  localparam logic signed [SUM_W-1:0]    HALF_S = SUM_W'(1) <<< 29;
  localparam logic signed [SUM_W-1:0] MAXV =
    {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] MINV = ~MAXV;

  logic [3:0] v;

  // stage 1: quadrant fix
  logic                          cmd1;
  logic signed [COORD_WIDTH-1:0] p1 [3];
  logic signed [TRIG_W-1:0]      sp1, cp1, sy1, cy1;

  // stage 2: cross terms
  logic                          cmd2;
  logic signed [COORD_WIDTH-1:0] p2 [3];
  logic signed [TRIG_W-1:0]      sp2, cp2, sy2, cy2, spsy, cpsy, spcy, cpcy;

  // stage 3: products
  logic signed [PROD_W-1:0]      prod [3][3];

  logic signed [2*TRIG_W-1:0]    m_spsy, m_cpsy, m_spcy, m_cpcy;
  logic signed [COEF_W-1:0]      mat [3][3];
  logic signed [COEF_W-1:0]      row [3][3];
  logic signed [SUM_W-1:0]       acc [3];
  out_word_t                     data_next;

  always_comb begin
    m_spsy = sp1 * sy1 + HALF_T;
    m_cpsy = cp1 * sy1 + HALF_T;
    m_spcy = sp1 * cy1 + HALF_T;
    m_cpcy = cp1 * cy1 + HALF_T;
  end

  always_comb begin
    mat[0][0] = cy2;
    mat[0][1] = -spsy;
    mat[0][2] = -cpsy;
    mat[1][0] = '0;
    mat[1][1] = cp2;
    mat[1][2] = -sp2;
    mat[2][0] = sy2;
    mat[2][1] = spcy;
    mat[2][2] = cpcy;
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        row[r][j] = cmd2 ? mat[j][r] : mat[r][j];
      end
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] s;
    logic                    sat;
    logic signed [COORD_WIDTH-1:0] res [3];
    sat = 1'b0;
    for (int r = 0; r < 3; r++) begin
      acc[r] = SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]) + SUM_W'(prod[r][2]) + HALF_S;
      s = acc[r] >>> 30;
      if (s > MAXV) begin
        res[r] = MAXV[COORD_WIDTH-1:0];
        sat    = 1'b1;
      end else if (s < MINV) begin
        res[r] = MINV[COORD_WIDTH-1:0];
        sat    = 1'b1;
      end else begin
        res[r] = s[COORD_WIDTH-1:0];
      end
    end
    data_next.rotated_x = res[0];
    data_next.rotated_y = res[1];
    data_next.rotated_z = res[2];
    data_next.saturated = sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], prev_valid};
    end
  end

  assign valid = v[3];

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1  <= prev.command;
      p1[0] <= prev.point_x;
      p1[1] <= prev.point_y;
      p1[2] <= prev.point_z;
      sp1   <= prev.pitch.flip ? -prev.pitch.y : prev.pitch.y;
      cp1   <= prev.pitch.flip ? -prev.pitch.x : prev.pitch.x;
      sy1   <= prev.yaw.flip ? -prev.yaw.y : prev.yaw.y;
      cy1   <= prev.yaw.flip ? -prev.yaw.x : prev.yaw.x;

      cmd2  <= cmd1;
      p2    <= p1;
      sp2   <= sp1;
      cp2   <= cp1;
      sy2   <= sy1;
      cy2   <= cy1;
      spsy  <= TRIG_W'(m_spsy >>> 30);
      cpsy  <= TRIG_W'(m_cpsy >>> 30);
      spcy  <= TRIG_W'(m_spcy >>> 30);
      cpcy  <= TRIG_W'(m_cpcy >>> 30);

      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          prod[r][j] <= PROD_W'(p2[j]) * PROD_W'(row[r][j]);
        end
      end

      data <= data_next;
    end
  end

endmodule
